>>> design/brenc_pkg.sv
// Package for the binary range encoder: shared constants, controller state
// type and the command/status bundles between controller and datapath.
// No dependencies.
package brenc_pkg;

  // Default widths of the probability scale and of the pending fill-byte run.
  localparam int PROB_BITS_DEF = 12;
  localparam int RUN_BITS_DEF  = 32;

  // Fixed field widths of the interface.
  localparam int PROB_IN_W = 12;
  localparam int COUNT_W   = 32;
  localparam int BYTE_W    = 8;

  // Coder word sizes.
  localparam int RANGE_W = 32;
  localparam int LOW_W   = RANGE_W + 1;

  // Byte shifts done by a flush, and the cap on shifts for one item.
  localparam int MAX_SHIFTS = 5;
  localparam int SHIFT_CNT_W = 3;

  // Input kind codes.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [BYTE_W-1:0] FF_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SHIFT,
    S_DRAIN
  } brenc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the product of range and probability
    logic update;      // apply the symbol to low and range
    logic shift;       // perform one byte shift of low
    logic shift_range; // also scale range by 256 on this shift
    logic push;        // move the held result to the output, not last
    logic drain;       // move the held result to the output as last
  } brenc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_low;   // range is below 2^24
    logic release_now; // the next byte shift releases bytes
    logic held_valid;  // a result is held back waiting for its last flag
    logic slot_free;   // the output register can take a result this cycle
  } brenc_status_t;

endpackage

>>> design/brenc_ctrl.sv
// Controller of the binary range encoder: sequences the update, the byte
// shifts and the final result of each item. Depends on brenc_pkg.
module brenc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    kind,
  output logic                    in_ready,
  input  brenc_pkg::brenc_status_t status,
  output brenc_pkg::brenc_cmd_t    cmd
);
  import brenc_pkg::*;

  brenc_state_t           state;
  brenc_state_t           state_next;
  logic [SHIFT_CNT_W-1:0] cnt;
  logic                   flush;
  logic                   done;
  logic                   stall;

  // Encodes stop shifting once range is renormalized; both kinds stop at the cap.
  assign done  = (cnt == SHIFT_CNT_W'(MAX_SHIFTS)) || (!flush && !status.range_low);
  // A release must push the held result out, which needs a free output slot.
  assign stall = status.release_now && status.held_valid && !status.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        cnt   <= '0;
        flush <= (kind == KIND_FLUSH);
      end else if (cmd.shift) begin
        cnt <= cnt + SHIFT_CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (kind == KIND_FLUSH) ? S_SHIFT : S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_SHIFT;
      S_SHIFT: begin
        if (done) begin
          state_next = status.held_valid ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (status.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_UPDATE: cmd.update = 1'b1;
      S_SHIFT: begin
        if (!done && !stall) begin
          cmd.shift       = 1'b1;
          cmd.shift_range = !flush;
          cmd.push        = status.release_now && status.held_valid;
        end
      end
      S_DRAIN: cmd.drain = status.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/brenc_dp.sv
// Datapath of the binary range encoder: coder state, the probability
// multiplier, the byte shifter with carry cache, and the output register.
// Depends on brenc_pkg.
module brenc_dp #(
  parameter int PROB_BITS = brenc_pkg::PROB_BITS_DEF,
  parameter int RUN_BITS  = brenc_pkg::RUN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [brenc_pkg::PROB_IN_W-1:0]     prob_one,
  input  logic                                bit_value,
  input  brenc_pkg::brenc_cmd_t               cmd,
  output brenc_pkg::brenc_status_t            status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                has_lead,
  output logic [brenc_pkg::BYTE_W-1:0]        lead_byte,
  output logic [brenc_pkg::BYTE_W-1:0]        fill_byte,
  output logic [brenc_pkg::COUNT_W-1:0]       fill_count,
  output logic                                last
);
  import brenc_pkg::*;

  localparam int CLAMP_W = 17;
  localparam logic [CLAMP_W-1:0] PROB_MAX = CLAMP_W'((1 << PROB_BITS) - 1);
  localparam int PROD_W = RANGE_W + PROB_BITS;

  // Coder state.
  logic [LOW_W-1:0]    low;
  logic [RANGE_W-1:0]  range;
  logic [BYTE_W-1:0]   cache;
  logic [RUN_BITS-1:0] pend;
  logic                first;

  // Captured item.
  logic [PROD_W-1:0]   prod;
  logic                bit_q;

  // Result held back until it is known whether it is the item's last.
  logic                held_valid;
  logic                held_lead_en;
  logic [BYTE_W-1:0]   held_lead;
  logic [BYTE_W-1:0]   held_fill;
  logic [RUN_BITS-1:0] held_count;

  // Output register.
  logic                out_lead_en;
  logic [BYTE_W-1:0]   out_lead;
  logic [BYTE_W-1:0]   out_fill;
  logic [RUN_BITS-1:0] out_count;
  logic                out_last;

  logic [CLAMP_W-1:0]   p_wide;
  logic [PROB_BITS-1:0] p_eff;
  logic [RANGE_W-1:0]   bound;
  logic                 carry;
  logic                 rel;
  logic                 load_out;

  always_comb begin
    p_wide = CLAMP_W'(prob_one);
    if (p_wide == '0) begin
      p_wide = CLAMP_W'(1);
    end
    if (p_wide > PROB_MAX) begin
      p_wide = PROB_MAX;
    end
    p_eff = p_wide[PROB_BITS-1:0];
  end

  assign bound = prod[PROB_BITS +: RANGE_W];
  assign carry = low[LOW_W-1];
  // Bytes are released unless the top byte is 0xFF with no carry.
  assign rel   = carry || (low[RANGE_W-1 -: BYTE_W] != FF_BYTE);

  assign status.range_low   = (range[RANGE_W-1 -: BYTE_W] == '0);
  assign status.release_now = rel;
  assign status.held_valid  = held_valid;
  assign status.slot_free   = !out_valid || out_ready;

  assign load_out = cmd.push || cmd.drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      low        <= '0;
      range      <= '1;
      cache      <= '0;
      pend       <= '0;
      first      <= 1'b1;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (bit_q) begin
          range <= bound;
        end else begin
          low   <= low + LOW_W'(bound);
          range <= range - bound;
        end
      end else if (cmd.shift) begin
        if (rel) begin
          first      <= 1'b0;
          pend       <= '0;
          cache      <= low[RANGE_W-1 -: BYTE_W];
          held_valid <= 1'b1;
        end else if (pend != '1) begin
          pend <= pend + RUN_BITS'(1);
        end
        low <= {1'b0, low[RANGE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        if (cmd.shift_range) begin
          range <= {range[RANGE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
      end
      if (cmd.drain) begin
        held_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod  <= PROD_W'(range) * PROD_W'(p_eff);
      bit_q <= bit_value;
    end
    if (cmd.shift && rel) begin
      held_lead_en <= !first;
      held_lead    <= first ? '0 : cache + BYTE_W'(carry);
      held_fill    <= carry ? '0 : FF_BYTE;
      held_count   <= pend;
    end
    if (load_out) begin
      out_lead_en <= held_lead_en;
      out_lead    <= held_lead;
      out_fill    <= held_fill;
      out_count   <= held_count;
      out_last    <= cmd.drain;
    end
  end

  assign has_lead   = out_lead_en;
  assign lead_byte  = out_lead;
  assign fill_byte  = out_fill;
  assign fill_count = COUNT_W'(out_count);
  assign last       = out_last;

endmodule

>>> design/binary_range_encoder_top.sv
// Top level of the binary range encoder: joins the controller and the
// datapath. Depends on brenc_pkg, brenc_ctrl and brenc_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_ready  | kind, prob_one, bit_value
//   output   | out_valid / out_ready| has_lead, lead_byte, fill_byte, fill_count, last
//
// An encode item loads the registered multiply, applies the low/range update, then
// makes its byte shifts (0 to 2); a flush skips the update and makes its 5 shifts.
// A drain step follows when the item released bytes, to send its last result. The
// pace is set by the single byte shifter doing one shift per cycle unless it stalls.
// Reset is synchronous. A shift that releases bytes while a result is held waits
// while a prior result still sits unaccepted in the output register.
module binary_range_encoder_top #(
  parameter int PROB_BITS = brenc_pkg::PROB_BITS_DEF,
  parameter int RUN_BITS  = brenc_pkg::RUN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [brenc_pkg::PROB_IN_W-1:0] prob_one,
  input  logic                          bit_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          has_lead,
  output logic [brenc_pkg::BYTE_W-1:0]  lead_byte,
  output logic [brenc_pkg::BYTE_W-1:0]  fill_byte,
  output logic [brenc_pkg::COUNT_W-1:0] fill_count,
  output logic                          last
);
  import brenc_pkg::*;

  brenc_cmd_t    cmd;
  brenc_status_t status;

  brenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brenc_dp #(
    .PROB_BITS (PROB_BITS),
    .RUN_BITS  (RUN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .prob_one   (prob_one),
    .bit_value  (bit_value),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .has_lead   (has_lead),
    .lead_byte  (lead_byte),
    .fill_byte  (fill_byte),
    .fill_count (fill_count),
    .last       (last)
  );

endmodule

>>> design/brenc_checker.sv
// Port-level checker for the binary range encoder, bound to the top level.
// Depends on brenc_pkg and binary_range_encoder_top.
module brenc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          has_lead,
  input logic [brenc_pkg::BYTE_W-1:0]  lead_byte,
  input logic [brenc_pkg::BYTE_W-1:0]  fill_byte,
  input logic [brenc_pkg::COUNT_W-1:0] fill_count,
  input logic                          last
);
  import brenc_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lead_byte) && $stable(fill_byte)
      && $stable(fill_count) && $stable(has_lead) && $stable(last))
    else $error("output payload changed while stalled");

  // Items are worked one at a time: an accepted transaction closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // Run bytes are 0xFF plus carry, so only 0xFF or 0x00.
  a_fill_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_byte == FF_BYTE || fill_byte == '0))
    else $error("fill byte is neither 0xFF nor 0x00");

  // A result without a lead byte, as the very first release, shows a zero lead byte.
  a_no_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_lead |-> lead_byte == '0)
    else $error("lead byte nonzero without a lead");

endmodule

bind binary_range_encoder_top brenc_checker u_brenc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .has_lead   (has_lead),
  .lead_byte  (lead_byte),
  .fill_byte  (fill_byte),
  .fill_count (fill_count),
  .last       (last)
);

>>> tb/brenc_stream_checker.sv
// Checker for the binary range encoder: watches both channels, keeps its own
// copy of the coder state and compares every released byte group in order.
// Depends on brenc_pkg.
`timescale 1ns / 1ps

module brenc_stream_checker
  import brenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 kind,
  input  logic [PROB_IN_W-1:0] prob_one,
  input  logic                 bit_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 has_lead,
  input  logic [BYTE_W-1:0]    lead_byte,
  input  logic [BYTE_W-1:0]    fill_byte,
  input  logic [COUNT_W-1:0]   fill_count,
  input  logic                 last,
  output int                   n_fail,
  output int                   n_pending,
  output int                   n_items,
  output int                   n_flushes,
  output int                   n_releases,
  output int                   n_carries,
  output int                   longest_run
);

  localparam logic [PROB_IN_W-1:0] PROB_MAX = PROB_IN_W'((1 << PROB_BITS_DEF) - 1);
  localparam logic [LOW_W-1:0]     TOP_FF   = 33'h0FF000000;
  localparam logic [RANGE_W-1:0]   RANGE_MIN = 32'h01000000;

  typedef struct packed {
    logic               has_lead;
    logic [BYTE_W-1:0]  lead_byte;
    logic [BYTE_W-1:0]  fill_byte;
    logic [COUNT_W-1:0] fill_count;
    logic               last;
  } byte_release_t;

  // Coder state as the block should hold it.
  logic [LOW_W-1:0]   c_low;
  logic [RANGE_W-1:0] c_range;
  logic [BYTE_W-1:0]  c_cache;
  logic [COUNT_W-1:0] c_run;
  logic               c_first;

  byte_release_t release_q[$];

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // One byte shift of low. Either the cached byte and its fill run leave the
  // coder, or a top byte of 0xFF without carry just lengthens the run.
  task shift_out_byte;
    logic          carry;
    byte_release_t r;
    begin
      carry = c_low[RANGE_W];
      if (c_low < TOP_FF || carry) begin
        r.has_lead   = !c_first;
        r.lead_byte  = c_first ? 8'h00 : c_cache + BYTE_W'(carry);
        r.fill_byte  = FF_BYTE + BYTE_W'(carry);
        r.fill_count = c_run;
        r.last       = 1'b0;
        release_q.push_back(r);
        n_releases++;
        if (carry) n_carries++;
        if (c_run > longest_run) longest_run = c_run;
        c_first = 1'b0;
        c_run   = '0;
        c_cache = c_low[31:24];
      end else if (c_run != '1) begin
        c_run++;
      end
      c_low = {1'b0, c_low[23:0], 8'h00};
    end
  endtask

  task predict_item(input logic k, input logic [PROB_IN_W-1:0] p_in, input logic b);
    logic [PROB_IN_W-1:0]         p;
    logic [RANGE_W+PROB_IN_W-1:0] prod;
    logic [RANGE_W-1:0]           bound;
    int                           nshift;
    int                           before_n;
    byte_release_t                r;
    begin
      before_n = release_q.size();
      if (k == KIND_FLUSH) begin
        repeat (MAX_SHIFTS) shift_out_byte();
      end else begin
        p = p_in;
        if (p == '0) p = PROB_IN_W'(1);
        if (p > PROB_MAX) p = PROB_MAX;
        prod  = (RANGE_W+PROB_IN_W)'(c_range) * (RANGE_W+PROB_IN_W)'(p);
        bound = prod[PROB_BITS_DEF +: RANGE_W];
        if (b) begin
          c_range = bound;
        end else begin
          c_low   = c_low + LOW_W'(bound);
          c_range = c_range - bound;
        end
        nshift = 0;
        while (c_range < RANGE_MIN && nshift < MAX_SHIFTS) begin
          c_range = c_range << 8;
          shift_out_byte();
          nshift++;
        end
      end
      if (release_q.size() > before_n) begin
        r = release_q.pop_back();
        r.last = 1'b1;
        release_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    byte_release_t want;
    if (rst) begin
      c_low   = '0;
      c_range = '1;
      c_cache = '0;
      c_run   = '0;
      c_first = 1'b1;
      release_q.delete();
      n_fail      = 0;
      n_items     = 0;
      n_flushes   = 0;
      n_releases  = 0;
      n_carries   = 0;
      longest_run = 0;
    end else begin
      // Results are checked before this edge's input is predicted, so a result
      // can never be matched against an item accepted in the same cycle.
      if (out_valid && out_ready) begin
        if (release_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with nothing expected, actual lead %0h fill %0h count %0d",
                   $time, lead_byte, fill_byte, fill_count);
        end else begin
          want = release_q.pop_front();
          check_field("has_lead", 32'(want.has_lead), 32'(has_lead));
          check_field("lead_byte", 32'(want.lead_byte), 32'(lead_byte));
          check_field("fill_byte", 32'(want.fill_byte), 32'(fill_byte));
          check_field("fill_count", want.fill_count, fill_count);
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (in_valid && in_ready) begin
        n_items++;
        if (kind == KIND_FLUSH) n_flushes++;
        predict_item(kind, prob_one, bit_value);
      end
    end
    n_pending = release_q.size();
  end

endmodule

>>> tb/binary_range_encoder_top_tb.sv
// Testbench top for the binary range encoder: clock, reset, stimulus and the
// verdict. Depends on brenc_pkg, binary_range_encoder_top and brenc_stream_checker.
`timescale 1ns / 1ps

module binary_range_encoder_top_tb;
  import brenc_pkg::*;

  localparam int  HALF_PERIOD = 5;
  localparam int  N_RANDOM    = 240;
  localparam int  HOLD_AT     = 30;
  localparam int  HOLD_CYCLES = 400;
  localparam int  TAIL_CYCLES = 30;
  localparam real LIMIT_NS    = 3000000.0;

  // Flavors of random symbol streams.
  typedef enum int {
    MIX_UNIFORM,
    MIX_LIKELY,
    MIX_TOPHEAVY,
    MIX_COLLAPSE
  } mix_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = KIND_ENCODE;
  logic [PROB_IN_W-1:0] prob_one = '0;
  logic                 bit_value = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 has_lead;
  logic [BYTE_W-1:0]    lead_byte;
  logic [BYTE_W-1:0]    fill_byte;
  logic [COUNT_W-1:0]   fill_count;
  logic                 last;

  int n_fail, n_pending, n_items, n_flushes, n_releases, n_carries, longest_run;
  bit sender_calm = 1'b0;

  always #(HALF_PERIOD) clk = ~clk;

  binary_range_encoder_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .prob_one(prob_one), .bit_value(bit_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .has_lead(has_lead), .lead_byte(lead_byte), .fill_byte(fill_byte),
    .fill_count(fill_count), .last(last)
  );

  brenc_stream_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .prob_one(prob_one), .bit_value(bit_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .has_lead(has_lead), .lead_byte(lead_byte), .fill_byte(fill_byte),
    .fill_count(fill_count), .last(last),
    .n_fail(n_fail), .n_pending(n_pending), .n_items(n_items),
    .n_flushes(n_flushes), .n_releases(n_releases), .n_carries(n_carries),
    .longest_run(longest_run)
  );

  // Offers one transaction and returns at the edge that accepts it; valid is
  // left high so a back-to-back transaction sent with no gap does not drop it.
  task automatic send_item(input logic k, input logic [PROB_IN_W-1:0] p, input logic b);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    prob_one  <= p;
    bit_value <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    mix_t                 mix;
    int                   left;
    logic                 k;
    logic                 b;
    logic [PROB_IN_W-1:0] p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: probability extremes, both symbols, flushes on an empty run,
    // then a string of unlikely zeros that pushes low toward its top byte.
    send_item(KIND_ENCODE, 12'd0, 1'b1);
    send_item(KIND_ENCODE, 12'd0, 1'b0);
    send_item(KIND_ENCODE, 12'd4095, 1'b1);
    send_item(KIND_ENCODE, 12'd4095, 1'b0);
    send_item(KIND_ENCODE, 12'd1, 1'b0);
    send_item(KIND_ENCODE, 12'd1, 1'b1);
    send_item(KIND_ENCODE, 12'd2048, 1'b0);
    send_item(KIND_ENCODE, 12'd2048, 1'b1);
    send_item(KIND_ENCODE, 12'hAAA, 1'b1);
    send_item(KIND_ENCODE, 12'h555, 1'b0);
    send_item(KIND_FLUSH, 12'hFFF, 1'b1);
    send_item(KIND_FLUSH, 12'h000, 1'b0);
    repeat (8) send_item(KIND_ENCODE, 12'd4095, 1'b0);
    send_item(KIND_ENCODE, 12'd4094, 1'b1);
    send_item(KIND_FLUSH, 12'd7, 1'b0);

    left = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (left == 0) begin
        mix  = mix_t'($urandom_range(0, 3));
        left = $urandom_range(8, 24);
      end
      left--;
      sender_calm = (i >= 110 && i < 150);

      // Let the encoder drain completely once before carrying on.
      if (i == 180) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (n_pending == 0);
      end

      k = ($urandom_range(0, 99) < 6) ? KIND_FLUSH : KIND_ENCODE;
      b = 1'($urandom_range(0, 1));
      case (mix)
        MIX_UNIFORM: begin
          p = PROB_IN_W'($urandom_range(0, 4095));
        end
        MIX_LIKELY: begin
          p = PROB_IN_W'($urandom_range(3500, 4095));
          b = ($urandom_range(0, 9) != 0);
        end
        MIX_TOPHEAVY: begin
          // Unlikely zeros stack low near the top of the range: fill runs and carries.
          p = 12'd4095 - PROB_IN_W'($urandom_range(0, 15));
          b = ($urandom_range(0, 4) == 0);
        end
        default: begin
          p = PROB_IN_W'($urandom_range(0, 255));
          b = ($urandom_range(0, 3) != 0);
        end
      endcase
      send_item(k, p, b);
    end
    send_item(KIND_FLUSH, PROB_IN_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    @(posedge clk);
    wait (n_pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions (%0d flushes) and %0d byte releases,",
             n_items, n_flushes, n_releases);
    $display("%0d of them with carry, longest fill run %0d bytes.", n_carries, longest_run);
    if (n_fail == 0 && n_pending == 0)
      $display("[binary_range_encoder_top] OK");
    else
      $display("[binary_range_encoder_top] ERROR");
    $finish;
  end

  // The receiver stalls at random, runs without stalls for a stretch, and holds
  // off once for long enough that the encoder backs up into its input.
  initial begin : sink
    int got;
    int stall;
    got = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (got == HOLD_AT)
        stall = HOLD_CYCLES;
      else if (got >= 100 && got < 160)
        stall = 0;
      else
        stall = $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout with %0d results still expected", n_pending);
    $display("[binary_range_encoder_top] ERROR");
    $finish;
  end

endmodule
